FILE: rtl/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants and types for the perspective point projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned DOT_W     = 50;
  localparam int unsigned MAG_W     = 48;
  localparam int unsigned SIZE_W    = 14;
  localparam int unsigned HALF_W    = SIZE_W + 15;
  localparam int unsigned SPLIT_W   = MAG_W / 2;
  localparam int unsigned DVD_W     = MAG_W + HALF_W;
  localparam int unsigned DIV_STEPS = 34;
  localparam int unsigned REM_W     = MAG_W;
  localparam int unsigned SUM_W     = DIV_STEPS + 3;

  localparam logic signed [DOT_W-1:0] NEAR_LIMIT_Q16 = DOT_W'(66);

  localparam logic [2:0] REG_COL0_R01 = 3'd0;
  localparam logic [2:0] REG_COL0_R23 = 3'd1;
  localparam logic [2:0] REG_COL1_R01 = 3'd2;
  localparam logic [2:0] REG_COL1_R23 = 3'd3;
  localparam logic [2:0] REG_COL3_R01 = 3'd4;
  localparam logic [2:0] REG_COL3_R23 = 3'd5;
  localparam logic [2:0] REG_WIDTH    = 3'd6;
  localparam logic [2:0] REG_HEIGHT   = 3'd7;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1080);

  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } tag_t;

endpackage

FILE: rtl/ppp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ppp_div import ppp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [REM_W-1:0]     rem_in,
  input  logic [DIV_STEPS-1:0] low_in,
  input  logic [REM_W-1:0]     den_in,
  output logic [DIV_STEPS-1:0] quo_out
);

  logic [REM_W-1:0]     rem_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_r [DIV_STEPS];
  logic [REM_W-1:0]     den_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [REM_W-1:0]     src_rem;
    logic [DIV_STEPS-1:0] src_low;
    logic [REM_W-1:0]     src_den;
    logic [DIV_STEPS-1:0] src_quo;
    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic [REM_W-1:0]     rem_nxt;
    logic                 qbit;

    if (k == 0) begin : g_first
      assign src_rem = rem_in;
      assign src_low = low_in;
      assign src_den = den_in;
      assign src_quo = '0;
    end else begin : g_next
      assign src_rem = rem_r[k-1];
      assign src_low = low_r[k-1];
      assign src_den = den_r[k-1];
      assign src_quo = quo_r[k-1];
    end

    always_comb begin
      trial = {src_rem, src_low[DIV_STEPS-1]};
      diff  = trial - {1'b0, src_den};
      qbit  = (trial >= {1'b0, src_den});
      rem_nxt = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= {src_low[DIV_STEPS-2:0], 1'b0};
        den_r[k] <= src_den;
        quo_r[k] <= {src_quo[DIV_STEPS-2:0], qbit};
      end
    end
  end

  assign quo_out = quo_r[DIV_STEPS-1];

endmodule

FILE: rtl/perspective_point_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_projection
// Projects a Q16.16 world point through a 4x4 matrix to viewport pixels.
// ----------------------------------------------------------------------------
// Pipeline: six arithmetic stages, the 34-stage quotient pipeline and the
//   output register.
// Throughput: one point per cycle; the whole pipeline holds while a result
//   waits on out_tready.
// Reset: synchronous, active low; clears valid bits, coefficients to 0 and
//   the viewport to 1920 x 1080.
module perspective_point_projection import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // point_x, point_y, point_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // screen_x, screen_y
  output logic [0:0]  out_tuser,  // visible
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [63:0]       coef_r [6];
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [2:0]        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_idx)
        REG_COL0_R01: coef_r[0] <= cfg_pwdata;
        REG_COL0_R23: coef_r[1] <= cfg_pwdata;
        REG_COL1_R01: coef_r[2] <= cfg_pwdata;
        REG_COL1_R23: coef_r[3] <= cfg_pwdata;
        REG_COL3_R01: coef_r[4] <= cfg_pwdata;
        REG_COL3_R23: coef_r[5] <= cfg_pwdata;
        REG_WIDTH:    width_r   <= cfg_pwdata[SIZE_W-1:0];
        REG_HEIGHT:   height_r  <= cfg_pwdata[SIZE_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COL0_R01: cfg_prdata = coef_r[0];
      REG_COL0_R23: cfg_prdata = coef_r[1];
      REG_COL1_R01: cfg_prdata = coef_r[2];
      REG_COL1_R23: cfg_prdata = coef_r[3];
      REG_COL3_R01: cfg_prdata = coef_r[4];
      REG_COL3_R23: cfg_prdata = coef_r[5];
      REG_WIDTH:    cfg_prdata = {{(64-SIZE_W){1'b0}}, width_r};
      REG_HEIGHT:   cfg_prdata = {{(64-SIZE_W){1'b0}}, height_r};
      default:      cfg_prdata = '0;
    endcase
  end

  logic en;
  logic out_valid_r;

  assign en        = !(out_valid_r && !out_tready);
  assign in_tready = en;

  // stage 1: coefficient products, floored to Q16.16
  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [PROD_W-1:0]  prod_nxt [9];
  logic signed [PROD_W-1:0]  prod_r   [9];
  logic signed [COORD_W-1:0] k3_r     [3];
  logic                      v1_r;

  assign px = in_tdata[31:0];
  assign py = in_tdata[63:32];
  assign pz = in_tdata[95:64];

  always_comb begin
    logic signed [63:0] p;
    for (int c = 0; c < 3; c++) begin
      p = $signed(coef_r[2*c][31:0]) * px;
      prod_nxt[3*c]   = p[63:16];
      p = $signed(coef_r[2*c][63:32]) * py;
      prod_nxt[3*c+1] = p[63:16];
      p = $signed(coef_r[2*c+1][31:0]) * pz;
      prod_nxt[3*c+2] = p[63:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) prod_r[i] <= prod_nxt[i];
      for (int c = 0; c < 3; c++) k3_r[c] <= $signed(coef_r[2*c+1][63:32]);
    end
  end

  // stage 2: dot products
  logic signed [DOT_W-1:0] dot_r [3];
  logic                    v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dot_r[c] <= DOT_W'(prod_r[3*c]) + DOT_W'(prod_r[3*c+1])
                  + DOT_W'(prod_r[3*c+2]) + DOT_W'(k3_r[c]);
      end
    end
  end

  // stage 3: depth test and magnitudes
  logic [MAG_W-1:0]        mag_x_r, mag_y_r, wd3_r;
  logic                    neg_x3_r, neg_y3_r, vis3_r, v3_r;
  logic signed [DOT_W-1:0] neg_d0, neg_d1;

  assign neg_d0 = -dot_r[0];
  assign neg_d1 = -dot_r[1];

  always_ff @(posedge clk) begin
    if (en) begin
      neg_x3_r <= dot_r[0][DOT_W-1];
      neg_y3_r <= dot_r[1][DOT_W-1];
      mag_x_r  <= dot_r[0][DOT_W-1] ? neg_d0[MAG_W-1:0] : dot_r[0][MAG_W-1:0];
      mag_y_r  <= dot_r[1][DOT_W-1] ? neg_d1[MAG_W-1:0] : dot_r[1][MAG_W-1:0];
      wd3_r    <= dot_r[2][MAG_W-1:0];
      vis3_r   <= (dot_r[2] >= NEAR_LIMIT_Q16);
    end
  end

  // stage 4: partial products with half size
  logic [HALF_W-1:0]         half_w, half_h;
  logic [SPLIT_W+HALF_W-1:0] px_lo_r, px_hi_r, py_lo_r, py_hi_r;
  logic [MAG_W-1:0]          wd4_r;
  tag_t                      tag4_r;
  logic                      v4_r;

  assign half_w = {width_r, 15'd0};
  assign half_h = {height_r, 15'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      px_lo_r <= mag_x_r[SPLIT_W-1:0] * half_w;
      px_hi_r <= mag_x_r[MAG_W-1:SPLIT_W] * half_w;
      py_lo_r <= mag_y_r[SPLIT_W-1:0] * half_h;
      py_hi_r <= mag_y_r[MAG_W-1:SPLIT_W] * half_h;
      wd4_r   <= wd3_r;
      tag4_r  <= '{vis: vis3_r, neg_x: neg_x3_r, neg_y: neg_y3_r,
                   ovf_x: 1'b0, ovf_y: 1'b0};
    end
  end

  // stage 5: full dividends
  logic [DVD_W-1:0] dvd_x_r, dvd_y_r;
  logic [MAG_W-1:0] wd5_r;
  tag_t             tag5_r;
  logic             v5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_x_r <= (DVD_W'(px_hi_r) << SPLIT_W) + DVD_W'(px_lo_r);
      dvd_y_r <= (DVD_W'(py_hi_r) << SPLIT_W) + DVD_W'(py_lo_r);
      wd5_r   <= wd4_r;
      tag5_r  <= tag4_r;
    end
  end

  // stage 6: quotient range check
  logic [REM_W-1:0]     rem_x_r, rem_y_r, wd6_r;
  logic [DIV_STEPS-1:0] low_x_r, low_y_r;
  tag_t                 tag6_r;
  logic                 v6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x_r <= REM_W'(dvd_x_r[DVD_W-1:DIV_STEPS]);
      rem_y_r <= REM_W'(dvd_y_r[DVD_W-1:DIV_STEPS]);
      low_x_r <= dvd_x_r[DIV_STEPS-1:0];
      low_y_r <= dvd_y_r[DIV_STEPS-1:0];
      wd6_r   <= wd5_r;
      tag6_r  <= '{vis: tag5_r.vis, neg_x: tag5_r.neg_x, neg_y: tag5_r.neg_y,
                   ovf_x: (REM_W'(dvd_x_r[DVD_W-1:DIV_STEPS]) >= wd5_r),
                   ovf_y: (REM_W'(dvd_y_r[DVD_W-1:DIV_STEPS]) >= wd5_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // quotient pipelines
  logic [DIV_STEPS-1:0] quo_x, quo_y;

  ppp_div u_div_x (
    .clk     (clk),
    .en      (en),
    .rem_in  (rem_x_r),
    .low_in  (low_x_r),
    .den_in  (wd6_r),
    .quo_out (quo_x)
  );

  ppp_div u_div_y (
    .clk     (clk),
    .en      (en),
    .rem_in  (rem_y_r),
    .low_in  (low_y_r),
    .den_in  (wd6_r),
    .quo_out (quo_y)
  );

  tag_t tag_r   [DIV_STEPS];
  logic vdiv_r  [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tag6_r;
      for (int i = 1; i < DIV_STEPS; i++) tag_r[i] <= tag_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STEPS; i++) vdiv_r[i] <= 1'b0;
    end else if (en) begin
      vdiv_r[0] <= v6_r;
      for (int i = 1; i < DIV_STEPS; i++) vdiv_r[i] <= vdiv_r[i-1];
    end
  end

  // output stage: offset, saturate and zero invisible points
  tag_t                    tag_o;
  logic [DIV_STEPS:0]      qe_x, qe_y;
  logic signed [SUM_W-1:0] off_x, off_y, sum_x, sum_y;
  logic signed [31:0]      sx_nxt, sy_nxt;
  logic signed [31:0]      sx_r, sy_r;
  logic                    vis_r;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sh80000000);

  assign tag_o = tag_r[DIV_STEPS-1];

  always_comb begin
    qe_x  = tag_o.ovf_x ? {1'b1, {DIV_STEPS{1'b0}}} : {1'b0, quo_x};
    qe_y  = tag_o.ovf_y ? {1'b1, {DIV_STEPS{1'b0}}} : {1'b0, quo_y};
    off_x = tag_o.neg_x ? -$signed(SUM_W'(qe_x)) : $signed(SUM_W'(qe_x));
    off_y = tag_o.neg_y ? -$signed(SUM_W'(qe_y)) : $signed(SUM_W'(qe_y));
    sum_x = $signed(SUM_W'(half_w)) + off_x;
    sum_y = $signed(SUM_W'(half_h)) - off_y;
    if (sum_x > SAT_HI)      sx_nxt = 32'sh7FFFFFFF;
    else if (sum_x < SAT_LO) sx_nxt = 32'sh80000000;
    else                     sx_nxt = sum_x[31:0];
    if (sum_y > SAT_HI)      sy_nxt = 32'sh7FFFFFFF;
    else if (sum_y < SAT_LO) sy_nxt = 32'sh80000000;
    else                     sy_nxt = sum_y[31:0];
    if (!tag_o.vis) begin
      sx_nxt = '0;
      sy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      vis_r <= tag_o.vis;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vdiv_r[DIV_STEPS-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {sy_r, sx_r};
  assign out_tuser  = vis_r;

endmodule
